>>> sv/slsb_pkg.sv
// shared types and constants of the sorted literal set builder
`default_nettype none

package slsb_pkg;

    localparam int LIT_W  = 32;
    localparam int HASH_W = 64;
    localparam int CNT_W  = 7;

    // hash starts at seed, then hash*31 + literal, done as (hash << 5) - hash
    localparam logic [HASH_W-1:0] HASH_SEED  = 64'd7;
    localparam int                HASH_SHIFT = 5;

    // control of the cell row, one beat at most per cycle
    typedef struct packed {
        logic ins;  // insert the broadcast literal at its sorted place
        logic shl;  // shift every cell one place toward the head
    } t_chain_ctl;

endpackage

`default_nettype wire

>>> sv/slsb_if.sv
// channel interfaces: literal input, result output, configuration write
`default_nettype none

interface slsb_lit_if;
    logic                       valid;
    logic                       ready;
    logic [slsb_pkg::LIT_W-1:0] literal;
    logic                       literal_present;
    logic                       set_end;

    modport source (output valid, literal, literal_present, set_end, input ready);
    modport sink (input valid, literal, literal_present, set_end, output ready);
endinterface

interface slsb_res_if;
    logic                        valid;
    logic                        ready;
    logic [slsb_pkg::LIT_W-1:0]  sorted_literal;
    logic                        is_last;
    logic [slsb_pkg::HASH_W-1:0] running_hash;
    logic [slsb_pkg::CNT_W-1:0]  distinct_count;
    logic                        has_complement;
    logic                        overflowed;
    logic                        set_empty;

    modport source (output valid, sorted_literal, is_last, running_hash, distinct_count,
                    has_complement, overflowed, set_empty, input ready);
    modport sink (input valid, sorted_literal, is_last, running_hash, distinct_count,
                  has_complement, overflowed, set_empty, output ready);
endinterface

interface slsb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [slsb_pkg::HASH_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> sv/sorted_literal_set_builder_core.sv
// top level of the sorted literal set builder: control, hash and result register
`default_nettype none

// Loads one set of literals (variable*2 + sign) one beat per cycle into a row of
// MAX_LITERALS cells that keeps them sorted and drops repeats; a new literal that
// finds the row full is dropped and flagged. The beat with set_end closes the set:
// its literal is placed in that cycle, then the row shifts toward the head one
// place per emitted result, with the emission rate set by the sink's ready.
// Input is not taken while a set is being emitted; the next set may start as soon
// as the last result sits in the output register. Every result of a non-empty set
// carries the running hash (seed 7, hash*31 + literal, mod 2^64); the last one also
// carries the distinct count, the complementary pair flag and the overflow flag.
// An empty set gives a single result with set_empty and the configured empty hash.
// Configuration writes are always taken and should come only while the block idles.

module sorted_literal_set_builder_core #(
    parameter int MAX_LITERALS = 64,
    parameter int LITERAL_BITS = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    slsb_lit_if.sink           i_lit,
    slsb_res_if.source         o_res,
    slsb_cfg_if.sink           i_cfg
);

    localparam int CW = $clog2(MAX_LITERALS + 1);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_count;   // cells in use, counts down while emitting
    logic [CW-1:0]                 r_total;   // distinct count of the set being emitted
    logic                          r_ovf;
    logic                          r_compl;
    logic [slsb_pkg::HASH_W-1:0]   r_hash;
    logic [slsb_pkg::HASH_W-1:0]   r_empty_hash;

    // result register
    logic                          r_oval;
    logic [slsb_pkg::LIT_W-1:0]    r_olit;
    logic                          r_olast;
    logic [slsb_pkg::HASH_W-1:0]   r_ohash;
    logic [slsb_pkg::CNT_W-1:0]    r_ocnt;
    logic                          r_ocompl;
    logic                          r_oovf;
    logic                          r_oempty;

    slsb_pkg::t_chain_ctl          w_ctl;
    logic [LITERAL_BITS-1:0]       w_lit;
    logic                          w_dup;
    logic [LITERAL_BITS-1:0]       w_head;
    logic [LITERAL_BITS-1:0]       w_next;
    logic                          w_lit_fire;
    logic                          w_full;
    logic                          w_emit;
    logic                          w_last;
    logic                          w_pair;
    logic [slsb_pkg::HASH_W-1:0]   w_hash_next;

    assign w_lit      = i_lit.literal[LITERAL_BITS-1:0];
    assign i_lit.ready = (r_state == ST_LOAD);
    assign i_cfg.ready = 1'b1;
    assign w_lit_fire = i_lit.valid && i_lit.ready;
    assign w_full     = (r_count == CW'(MAX_LITERALS));

    // a result beat leaves whenever the output register is free or being drained
    assign w_emit = (r_state == ST_EMIT) && (!r_oval || o_res.ready);

    assign w_ctl.ins = w_lit_fire && i_lit.literal_present && !w_dup && !w_full;
    assign w_ctl.shl = w_emit && (r_count != '0);

    assign w_last = (r_count <= CW'(1));
    // head and its successor are adjacent in order: same variable means both signs
    assign w_pair = (r_count > CW'(1)) &&
                    (w_head[LITERAL_BITS-1:1] == w_next[LITERAL_BITS-1:1]);

    // hash*31 + literal
    assign w_hash_next = (r_hash << slsb_pkg::HASH_SHIFT) - r_hash
                       + slsb_pkg::HASH_W'(w_head);

    slsb_chain #(
        .MAX_LITERALS (MAX_LITERALS),
        .LITERAL_BITS (LITERAL_BITS),
        .CW           (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_lit   (w_lit),
        .i_count (r_count),
        .o_dup   (w_dup),
        .o_head  (w_head),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_count      <= '0;
            r_total      <= '0;
            r_ovf        <= 1'b0;
            r_compl      <= 1'b0;
            r_hash       <= slsb_pkg::HASH_SEED;
            r_empty_hash <= '0;
            r_oval       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_empty_hash <= i_cfg.data;
            end

            unique case (r_state)
                ST_LOAD: begin
                    if (o_res.ready) begin
                        r_oval <= 1'b0;
                    end
                    if (w_lit_fire) begin
                        if (w_ctl.ins) begin
                            r_count <= r_count + CW'(1);
                        end
                        // new literal with no room left
                        if (i_lit.literal_present && !w_dup && w_full) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_lit.set_end) begin
                            r_total <= r_count + CW'(w_ctl.ins);
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_oval <= 1'b1;
                        if (r_count == '0) begin
                            // empty set
                            r_olit   <= '0;
                            r_olast  <= 1'b1;
                            r_ohash  <= r_empty_hash;
                            r_ocnt   <= '0;
                            r_ocompl <= 1'b0;
                            r_oovf   <= r_ovf;
                            r_oempty <= 1'b1;
                        end else begin
                            r_olit   <= slsb_pkg::LIT_W'(w_head);
                            r_olast  <= w_last;
                            r_ohash  <= w_hash_next;
                            r_ocnt   <= w_last ? slsb_pkg::CNT_W'(r_total) : '0;
                            r_ocompl <= w_last && (r_compl || w_pair);
                            r_oovf   <= w_last && r_ovf;
                            r_oempty <= 1'b0;
                            r_count  <= r_count - CW'(1);
                        end
                        if (w_last) begin
                            r_state <= ST_LOAD;
                            r_ovf   <= 1'b0;
                            r_compl <= 1'b0;
                            r_hash  <= slsb_pkg::HASH_SEED;
                        end else begin
                            r_compl <= r_compl || w_pair;
                            r_hash  <= w_hash_next;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_res.valid          = r_oval;
    assign o_res.sorted_literal = r_olit;
    assign o_res.is_last        = r_olast;
    assign o_res.running_hash   = r_ohash;
    assign o_res.distinct_count = r_ocnt;
    assign o_res.has_complement = r_ocompl;
    assign o_res.overflowed     = r_oovf;
    assign o_res.set_empty      = r_oempty;

`ifndef SYNTHESIS
    // the row never inserts and shifts in the same cycle
    a_ins_shl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins && w_ctl.shl))
        else $error("insert and shift together");

    // fill level stays within the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LITERALS))
        else $error("fill level beyond capacity");

    // a closing beat stops input until the set has been emitted
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lit_fire && i_lit.set_end) |=> !i_lit.ready)
        else $error("input taken right after a closing beat");

    // after the last result is loaded the row is empty and flags are clear
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_count == '0 && !r_ovf && o_res.is_last))
        else $error("state not cleared after last result");
`endif

endmodule

`default_nettype wire

>>> sv/slsb_cell.sv
// one cell of the sorted row: holds a literal, compares it, takes a neighbor's value
`default_nettype none

module slsb_cell #(
    parameter int LITERAL_BITS = 32
) (
    input  wire                       i_clk,
    input  wire slsb_pkg::t_chain_ctl i_ctl,
    input  wire  [LITERAL_BITS-1:0]   i_lit,
    input  wire                       i_occ,
    input  wire  [LITERAL_BITS-1:0]   i_left_val,
    input  wire                       i_left_gt,
    input  wire  [LITERAL_BITS-1:0]   i_right_val,
    output logic [LITERAL_BITS-1:0]   o_val,
    output logic                      o_gt,
    output logic                      o_eq
);

    logic [LITERAL_BITS-1:0] r_val;
    logic [LITERAL_BITS-1:0] n_val;

    // an empty cell counts as larger than any literal
    assign o_gt  = !i_occ || (r_val > i_lit);
    assign o_eq  = i_occ && (r_val == i_lit);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.shl) begin
            n_val = i_right_val;
        end else if (i_ctl.ins && o_gt) begin
            n_val = i_left_gt ? i_left_val : i_lit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

>>> sv/slsb_chain.sv
// row of cells holding the distinct literals in ascending order
`default_nettype none

module slsb_chain #(
    parameter int MAX_LITERALS = 64,
    parameter int LITERAL_BITS = 32,
    parameter int CW           = $clog2(MAX_LITERALS + 1)
) (
    input  wire                       i_clk,
    input  wire slsb_pkg::t_chain_ctl i_ctl,
    input  wire  [LITERAL_BITS-1:0]   i_lit,
    input  wire  [CW-1:0]             i_count,
    output logic                      o_dup,
    output logic [LITERAL_BITS-1:0]   o_head,
    output logic [LITERAL_BITS-1:0]   o_next
);

    logic [LITERAL_BITS-1:0] w_val [MAX_LITERALS];
    logic [MAX_LITERALS-1:0] w_gt;
    logic [MAX_LITERALS-1:0] w_eq;
    logic [MAX_LITERALS-1:0] w_occ;

    for (genvar g = 0; g < MAX_LITERALS; g++) begin : g_cell
        logic [LITERAL_BITS-1:0] w_left_val;
        logic                    w_left_gt;
        logic [LITERAL_BITS-1:0] w_right_val;

        assign w_occ[g] = i_count > CW'(g);

        if (g == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == MAX_LITERALS - 1) begin : g_tail
            assign w_right_val = '0;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        slsb_cell #(
            .LITERAL_BITS (LITERAL_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_lit       (i_lit),
            .i_occ       (w_occ[g]),
            .i_left_val  (w_left_val),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g]),
            .o_eq        (w_eq[g])
        );
    end

    assign o_dup  = |w_eq;
    assign o_head = w_val[0];
    assign o_next = w_val[1];

endmodule

`default_nettype wire

>>> verif/sorted_literal_set_builder_core_chk.sv
// checker for the sorted literal set builder: watches all three channels, predicts and compares
`timescale 1ns / 1ps

module sorted_literal_set_builder_core_chk #(
    parameter int MAX_LITS = 64,
    parameter int LIT_BITS = 32
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    slsb_lit_if  i_lit,
    slsb_res_if  i_res,
    slsb_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [slsb_pkg::LIT_W-1:0]  LIT_MASK  =
        {slsb_pkg::LIT_W{1'b1}} >> (slsb_pkg::LIT_W - LIT_BITS);
    localparam logic [slsb_pkg::HASH_W-1:0] HASH_MULT = 64'd31;

    typedef struct packed {
        logic [slsb_pkg::LIT_W-1:0]  lit;
        logic                        last;
        logic [slsb_pkg::HASH_W-1:0] hash;
        logic [slsb_pkg::CNT_W-1:0]  dcount;
        logic                        pair;
        logic                        spill;
        logic                        empty;
    } t_set_result;

    t_set_result                 result_q[$];
    logic [slsb_pkg::LIT_W-1:0]  held_lits [MAX_LITS];
    int                          held_n = 0;
    logic                        spill_seen = 1'b0;
    logic [slsb_pkg::HASH_W-1:0] empty_hash_q = '0;
    int                          fail_cnt = 0;
    int                          checked_n = 0;

    task automatic report_mismatch(input string what);
        fail_cnt++;
        $display("%0t chk result %0d: %s", $time, checked_n, what);
    endtask

    task automatic compare_field(input string name, input logic [slsb_pkg::HASH_W-1:0] got,
                                 input logic [slsb_pkg::HASH_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // sorted insert, repeats dropped; a new literal with no room only marks the spill
    task automatic place_literal(input logic [slsb_pkg::LIT_W-1:0] lit);
        int pos;
        int k;
        pos = 0;
        while (pos < held_n && held_lits[pos] < lit)
            pos++;
        if (pos < held_n && held_lits[pos] == lit)
            return;
        if (held_n >= MAX_LITS) begin
            spill_seen = 1'b1;
            return;
        end
        for (k = held_n; k > pos; k--)
            held_lits[k] = held_lits[k-1];
        held_lits[pos] = lit;
        held_n++;
    endtask

    // set closed: queue one result per distinct literal, or the single empty-set result
    task automatic close_set();
        t_set_result                 r;
        logic [slsb_pkg::HASH_W-1:0] h;
        logic                        pair;
        int                          i;
        if (held_n == 0) begin
            r       = '0;
            r.last  = 1'b1;
            r.hash  = empty_hash_q;
            r.spill = spill_seen;
            r.empty = 1'b1;
            result_q.push_back(r);
        end else begin
            h    = slsb_pkg::HASH_SEED;
            pair = 1'b0;
            for (i = 0; i < held_n; i++) begin
                h = h * HASH_MULT
                  + {{(slsb_pkg::HASH_W-slsb_pkg::LIT_W){1'b0}}, held_lits[i]};
                if (i + 1 < held_n && held_lits[i][slsb_pkg::LIT_W-1:1] ==
                                      held_lits[i+1][slsb_pkg::LIT_W-1:1])
                    pair = 1'b1;
                r      = '0;
                r.lit  = held_lits[i];
                r.last = (i == held_n - 1);
                r.hash = h;
                if (r.last) begin
                    r.dcount = slsb_pkg::CNT_W'(held_n);
                    r.pair   = pair;
                    r.spill  = spill_seen;
                end
                result_q.push_back(r);
            end
        end
        held_n     = 0;
        spill_seen = 1'b0;
    endtask

    task automatic check_result();
        t_set_result want;
        checked_n++;
        if (result_q.size() == 0) begin
            report_mismatch($sformatf("literal %h arrived with nothing expected",
                                      i_res.sorted_literal));
            return;
        end
        want = result_q.pop_front();
        compare_field("sorted_literal", i_res.sorted_literal, want.lit);
        compare_field("is_last", i_res.is_last, want.last);
        compare_field("running_hash", i_res.running_hash, want.hash);
        compare_field("distinct_count", i_res.distinct_count, want.dcount);
        compare_field("has_complement", i_res.has_complement, want.pair);
        compare_field("overflowed", i_res.overflowed, want.spill);
        compare_field("set_empty", i_res.set_empty, want.empty);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            empty_hash_q = '0;
            held_n       = 0;
            spill_seen   = 1'b0;
            result_q.delete();
        end else begin
            // older results are checked before a closing beat adds new ones
            if (i_res.valid && i_res.ready)
                check_result();
            if (i_cfg.valid && i_cfg.ready)
                empty_hash_q = i_cfg.data;
            if (i_lit.valid && i_lit.ready) begin
                if (i_lit.literal_present)
                    place_literal(i_lit.literal & LIT_MASK);
                if (i_lit.set_end)
                    close_set();
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= result_q.size();
    end

endmodule

>>> verif/sorted_literal_set_builder_core_tb.sv
// testbench top for the sorted literal set builder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module sorted_literal_set_builder_core_tb;

    localparam int CLK_HALF     = 4;     // 8 ns period
    localparam int RESET_CYCLES = 7;
    localparam int MAX_LITS     = 64;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 92;    // literal and closing beats per random phase
    localparam int HOLD_CYCLES  = 300;   // long output hold that backs the block up
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel

    // kinds of set the random part builds
    typedef enum int {SET_EMPTY, SET_POOL, SET_WIDE, SET_FILL, SET_SPILL} t_set_kind;

    logic i_clk;
    logic i_rst_n;

    slsb_lit_if lit_bus ();
    slsb_res_if res_bus ();
    slsb_cfg_if cfg_bus ();

    bit gaps_on = 1'b1;   // random idle bursts on both sides
    bit hold_req = 1'b0;  // asks the receiver for one long hold

    int items_sent = 0;
    int sets_closed = 0;
    int empty_sets = 0;
    int spill_sets = 0;
    int cfg_writes = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int chk_fails;
    int chk_pending;

    sorted_literal_set_builder_core #(
        .MAX_LITERALS(MAX_LITS),
        .LITERAL_BITS(slsb_pkg::LIT_W)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_lit  (lit_bus),
        .o_res  (res_bus),
        .i_cfg  (cfg_bus)
    );

    sorted_literal_set_builder_core_chk #(
        .MAX_LITS(MAX_LITS),
        .LIT_BITS(slsb_pkg::LIT_W)
    ) u_set_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lit       (lit_bus),
        .i_res       (res_bus),
        .i_cfg       (cfg_bus),
        .o_fail_count(chk_fails),
        .o_pending   (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog: any beat on any channel restarts the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((lit_bus.valid && lit_bus.ready) || (res_bus.valid && res_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res_bus.valid && res_bus.ready)
                results_seen <= results_seen + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("sorted_literal_set_builder_core regression: fail");
                $finish;
            end
        end
    end

    // result side: ready with random low bursts, plus one long hold on request;
    // one assignment to ready per edge
    initial begin
        int stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                res_bus.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // one literal-side beat; valid stays high on return so back-to-back beats need
    // no second assignment in the same step
    task automatic send_beat(input logic [slsb_pkg::LIT_W-1:0] lit, input logic pres,
                             input logic last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            lit_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        lit_bus.valid           <= 1'b1;
        lit_bus.literal         <= lit;
        lit_bus.literal_present <= pres;
        lit_bus.set_end         <= last;
        @(posedge i_clk);
        while (!lit_bus.ready)
            @(posedge i_clk);
        // beats that carry neither a literal nor a close are only noise
        if (pres || last)
            items_sent++;
        if (last)
            sets_closed++;
    endtask

    task automatic release_lit();
        lit_bus.valid <= 1'b0;
    endtask

    // wait for the checker to see every expected result, then let the block settle;
    // the first edges let a closing beat show up in the pending count
    task automatic wait_drained();
        repeat (2) @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_empty_hash(input logic [slsb_pkg::HASH_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        cfg_writes++;
    endtask

    // build and send one whole set, with the odd noise beat in between
    task automatic feed_set(input t_set_kind kind);
        logic [slsb_pkg::LIT_W-1:0] lits[$];
        logic [slsb_pkg::LIT_W-1:0] base;
        logic                       close_on_lit;
        int                         len;
        int                         i;
        case (kind)
            SET_EMPTY: begin
                len = 0;
            end
            SET_POOL: begin
                // narrow window of variables: repeats and complementary pairs are common
                base = $urandom;
                base[4:0] = '0;
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                    lits.push_back(base | $urandom_range(0, 31));
            end
            SET_WIDE: begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    lits.push_back($urandom);
            end
            default: begin
                // fill the store; odd places sometimes carry the complement of the one before
                for (i = 0; i < MAX_LITS; i++) begin
                    if (i % 2 == 1 && $urandom_range(0, 2) == 0)
                        lits.push_back(lits[i-1] ^ 1);
                    else
                        lits.push_back($urandom);
                end
                // past capacity: new literals are dropped and flagged
                if (kind == SET_SPILL) begin
                    repeat ($urandom_range(1, 4)) lits.push_back($urandom);
                    spill_sets++;
                end
                // repeats of stored literals with the store full are dropped silently
                repeat ($urandom_range(1, 3))
                    lits.push_back(lits[$urandom_range(0, MAX_LITS - 1)]);
                len = lits.size();
            end
        endcase
        if (len == 0)
            empty_sets++;
        close_on_lit = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat($urandom, 1'b0, 1'b0);
            send_beat(lits[i], 1'b1, close_on_lit && (i == len - 1));
        end
        if (!close_on_lit)
            send_beat($urandom, 1'b0, 1'b1);
    endtask

    initial begin
        int                          ph;
        int                          phase_start;
        int                          r;
        logic [slsb_pkg::HASH_W-1:0] hv;

        i_rst_n                 <= 1'b0;
        lit_bus.valid           <= 1'b0;
        lit_bus.literal         <= '0;
        lit_bus.literal_present <= 1'b0;
        lit_bus.set_end         <= 1'b0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.data            <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set with the reset empty hash
        send_beat(32'h0, 1'b0, 1'b1);
        // ignored beat, then extremes, a repeat, a complement pair, closed by a literal
        send_beat(32'hDEAD_BEEF, 1'b0, 1'b0);
        send_beat(32'h0000_0000, 1'b1, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_beat(32'h0000_0000, 1'b1, 1'b0);
        send_beat(32'h0000_0001, 1'b1, 1'b0);
        send_beat(32'hFFFF_FFFE, 1'b1, 1'b1);
        // single literal that also closes the set
        send_beat(32'h0000_0005, 1'b1, 1'b1);
        // no complement, a repeat, closed by a beat without a literal
        send_beat(32'h0000_000A, 1'b1, 1'b0);
        send_beat(32'h0000_000C, 1'b1, 1'b0);
        send_beat(32'h0000_000C, 1'b1, 1'b0);
        send_beat(32'h0000_0000, 1'b0, 1'b1);
        // closing literal repeats the only stored one
        send_beat(32'h0000_0007, 1'b1, 1'b0);
        send_beat(32'h0000_0007, 1'b1, 1'b1);
        release_lit();
        wait_drained();

        // empty hash at all ones, seen through empty sets
        write_empty_hash({slsb_pkg::HASH_W{1'b1}});
        send_beat(32'h1234_5678, 1'b0, 1'b1);
        send_beat(32'h8765_4321, 1'b0, 1'b0);
        send_beat(32'h0000_0000, 1'b0, 1'b1);

        // random phases, each behind a fresh empty hash; the last one runs without idling
        for (ph = 0; ph < PHASES; ph++) begin
            release_lit();
            wait_drained();
            case (ph)
                1:       hv = '0;
                3:       hv = 64'h8000_0000_0000_0001;
                default: hv = {$urandom, $urandom};
            endcase
            write_empty_hash(hv);
            gaps_on = (ph != PHASES - 1);
            // long hold while sets keep coming: the block fills and stalls its input
            if (ph == 1)
                hold_req = 1'b1;
            phase_start = items_sent;
            if (ph == 0)
                feed_set(SET_FILL);
            else if (ph == 2)
                feed_set(SET_SPILL);
            while (items_sent - phase_start < PHASE_ITEMS) begin
                r = $urandom_range(0, 9);
                feed_set(r == 0 ? SET_EMPTY : (r < 3 ? SET_WIDE : SET_POOL));
            end
        end
        release_lit();
        wait_drained();

        $display("summary: %0d items in %0d sets (%0d empty, %0d past capacity), %0d results",
                 items_sent, sets_closed, empty_sets, spill_sets, results_seen);
        $display("summary: %0d empty hash writes, one long output hold, %0d results left over",
                 cfg_writes, chk_pending);
        if (chk_fails == 0 && chk_pending == 0)
            $display("sorted_literal_set_builder_core regression: pass");
        else
            $display("sorted_literal_set_builder_core regression: fail");
        $finish;
    end

endmodule

>>> sorted_literal_set_builder_core.f
sv/slsb_pkg.sv
sv/slsb_if.sv
sv/slsb_cell.sv
sv/slsb_chain.sv
sv/sorted_literal_set_builder_core.sv
verif/sorted_literal_set_builder_core_chk.sv
verif/sorted_literal_set_builder_core_tb.sv
